@@ src/assert_macros.svh @@
// Assertion macros for the checker file of the filter block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("filter checker: property failed");

// Property checked every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("filter checker: property failed");

`endif

@@ src/cmdf_pkg.sv @@
// Package for the cross median denoise filter: sizes, codes and shared types.
// No dependencies; imported by every module of the block except cmdf_ram.
package cmdf_pkg;

   // Frame limits and pixel format
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int PIXEL_BITS  = 8;
   localparam int CFG_BITS    = 11;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int PEND_BITS   = COL_BITS + 1;

   // Register reset values
   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(576);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(460);

   // Register map
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Input action codes
   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // Sorting chain: odd-even transposition over the five cross taps
   localparam int MEDIAN_TAPS = 5;
   localparam int MEDIAN_IDX  = MEDIAN_TAPS / 2;
   localparam int SORT_CELLS  = MEDIAN_TAPS;
   localparam logic PHASE_EVEN = 1'b0;
   localparam logic PHASE_ODD  = 1'b1;

   // Output queue, sized to hold everything in flight
   localparam int PIPE_STAGES   = SORT_CELLS + 1;
   localparam int OUT_DEPTH     = 8;
   localparam int FIFO_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(OUT_DEPTH + 1);
   localparam int OCC_BITS      = $clog2(OUT_DEPTH + PIPE_STAGES + 1);

   typedef logic [PIXEL_BITS-1:0] pix_type;
   typedef logic [MEDIAN_TAPS-1:0][PIXEL_BITS-1:0] pix_vec_type;

   // One transaction moving down the sorting chain
   typedef struct packed {
      logic        valid;
      logic        last;
      pix_vec_type vals;
   } cell_data_type;

   // One result queued for the output channel
   typedef struct packed {
      pix_type filtered;
      logic    last;
   } out_item_type;

endpackage

@@ src/cmdf_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new data.
module cmdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and write-first read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/cmdf_sort_cell.sv @@
// One cell of the sorting chain: a compare-exchange round on the five taps.
// Depends on cmdf_pkg; instanced in a row by the top level.
module cmdf_sort_cell import cmdf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          phase,
   input  cell_data_type cell_in,
   output cell_data_type cell_out
);

   pix_vec_type   sorted;
   cell_data_type cell_ff;

   // even round swaps pairs 0-1 and 2-3, odd round swaps 1-2 and 3-4
   always_comb begin
      sorted = cell_in.vals;
      if (phase == PHASE_EVEN) begin
         if (cell_in.vals[0] > cell_in.vals[1]) begin
            sorted[0] = cell_in.vals[1];
            sorted[1] = cell_in.vals[0];
         end
         if (cell_in.vals[2] > cell_in.vals[3]) begin
            sorted[2] = cell_in.vals[3];
            sorted[3] = cell_in.vals[2];
         end
      end else begin
         if (cell_in.vals[1] > cell_in.vals[2]) begin
            sorted[1] = cell_in.vals[2];
            sorted[2] = cell_in.vals[1];
         end
         if (cell_in.vals[3] > cell_in.vals[4]) begin
            sorted[3] = cell_in.vals[4];
            sorted[4] = cell_in.vals[3];
         end
      end
   end

   // hand the round result to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.last <= cell_in.last;
      cell_ff.vals <= sorted;
   end

   assign cell_out = cell_ff;

endmodule

@@ src/cmdf_out_fifo.sv @@
// Output queue between the sorting chain and the result channel.
// Depends on cmdf_pkg; the top level keeps it from overflowing.
module cmdf_out_fifo import cmdf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  out_item_type             push_data,
   input  logic                     pop,
   output logic                     head_valid,
   output out_item_type             head_data,
   output logic [FIFO_CNT_BITS-1:0] count
);

   out_item_type              entries_ff [OUT_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]  count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

@@ src/cross_median_denoise_filter_top.sv @@
// Path: a result passes the acceptance register, the sorting chain and the output queue.
// Throughput: one transaction per cycle; input stalls only while eight results are queued
// or in flight. Each line memory takes one write per cycle.
// Reset: synchronous, active high; clears counters, pipeline and output queue and
// sets the frame size to 576 x 460. Line memories are not cleared (no clearing pass).
// Depends on cmdf_pkg, cmdf_ram, cmdf_sort_cell and cmdf_out_fifo.
module cross_median_denoise_filter_top import cmdf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [PIXEL_BITS-1:0]   req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PIXEL_BITS-1:0]   rsp_filtered,
   output logic                    rsp_frame_last,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   // control carried from acceptance to the memory read stage
   typedef struct packed {
      logic                work;
      logic                write;
      logic                produce;
      logic                last;
      logic                down_mid;
      logic                up_mid;
      logic                left_mid;
      logic                right_mid;
      logic [COL_BITS-1:0] col;
      pix_type             px;
   } ctl_type;

   logic [CFG_BITS-1:0]  frame_width_ff, frame_height_ff;
   logic [CFG_BITS-1:0]  w_eff, h_eff;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [PEND_BITS-1:0] pend_ff, pend_in;
   logic [COL_BITS:0]    col_inc;
   logic [ROW_BITS:0]    row_inc;
   logic                 accept, do_push, do_flush, last_col;
   ctl_type              s1_ff, s1_in;
   pix_type              window_ff, window_in;

   logic [2*PIXEL_BITS-1:0] pair_q;
   pix_type                 next_q;
   pix_type                 mid, above, up, down, left, right;

   cell_data_type cell_d [SORT_CELLS];
   cell_data_type cell_q [SORT_CELLS];

   out_item_type             fifo_in, fifo_head;
   logic [FIFO_CNT_BITS-1:0] fifo_count;
   logic [OCC_BITS-1:0]      occupancy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective frame size: zero acts as one, oversize acts as the maximum
   always_comb begin
      w_eff = frame_width_ff;
      if (frame_width_ff == '0) begin
         w_eff = CFG_BITS'(1);
      end else if (frame_width_ff > CFG_BITS'(MAX_WIDTH)) begin
         w_eff = CFG_BITS'(MAX_WIDTH);
      end
      h_eff = frame_height_ff;
      if (frame_height_ff == '0) begin
         h_eff = CFG_BITS'(1);
      end else if (frame_height_ff > CFG_BITS'(MAX_HEIGHT)) begin
         h_eff = CFG_BITS'(MAX_HEIGHT);
      end
   end

   // acceptance and position bookkeeping
   assign accept   = req_valid && req_ready;
   assign do_push  = (req_action == ACT_PUSH) && (pend_ff == '0);
   assign do_flush = (req_action == ACT_FLUSH) && (pend_ff != '0);
   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign last_col = (CFG_BITS'(col_inc) >= w_eff);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (accept && do_push) begin
         if (last_col) begin
            col_in = '0;
            if (CFG_BITS'(row_inc) >= h_eff) begin
               row_in  = '0;
               pend_in = PEND_BITS'(w_eff);
            end else begin
               row_in = ROW_BITS'(row_inc);
            end
         end else begin
            col_in = COL_BITS'(col_inc);
         end
      end else if (accept && do_flush) begin
         pend_in = pend_ff - 1'b1;
         if (pend_ff == PEND_BITS'(1)) begin
            col_in = '0;
         end else if (col_ff != COL_BITS'(MAX_WIDTH - 1)) begin
            col_in = COL_BITS'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // neighbor selects decided at acceptance, applied when memory data returns
   always_comb begin
      s1_in.work      = accept && (do_push || do_flush);
      s1_in.write     = accept && do_push;
      s1_in.produce   = accept && ((do_push && (row_ff != '0)) || do_flush);
      s1_in.last      = do_flush && (pend_ff == PEND_BITS'(1));
      s1_in.down_mid  = (req_action == ACT_FLUSH);
      s1_in.up_mid    = (req_action == ACT_FLUSH) ? (h_eff == CFG_BITS'(1))
                                                  : (row_ff == ROW_BITS'(1));
      s1_in.left_mid  = (col_ff == '0);
      s1_in.right_mid = last_col;
      s1_in.col       = col_ff;
      s1_in.px        = req_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.work    <= 1'b0;
         s1_ff.write   <= 1'b0;
         s1_ff.produce <= 1'b0;
      end else begin
         s1_ff.work    <= s1_in.work;
         s1_ff.write   <= s1_in.write;
         s1_ff.produce <= s1_in.produce;
      end
      s1_ff.last      <= s1_in.last;
      s1_ff.down_mid  <= s1_in.down_mid;
      s1_ff.up_mid    <= s1_in.up_mid;
      s1_ff.left_mid  <= s1_in.left_mid;
      s1_ff.right_mid <= s1_in.right_mid;
      s1_ff.col       <= s1_in.col;
      s1_ff.px        <= s1_in.px;
   end

   // line memories: {above, middle} read at the column, a middle copy at column + 1
   cmdf_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (s1_ff.write),
      .wr_addr (s1_ff.col),
      .wr_data ({mid, s1_ff.px}),
      .rd_addr (col_ff),
      .rd_data (pair_q)
   );

   cmdf_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (s1_ff.write),
      .wr_addr (s1_ff.col),
      .wr_data (s1_ff.px),
      .rd_addr (COL_BITS'(col_inc)),
      .rd_data (next_q)
   );

   // cross taps; an outside neighbor takes the center value
   assign mid   = pair_q[PIXEL_BITS-1:0];
   assign above = pair_q[2*PIXEL_BITS-1:PIXEL_BITS];
   assign up    = s1_ff.up_mid    ? mid : above;
   assign down  = s1_ff.down_mid  ? mid : s1_ff.px;
   assign left  = s1_ff.left_mid  ? mid : window_ff;
   assign right = s1_ff.right_mid ? mid : next_q;

   // left neighbor: center of the previous column
   assign window_in = s1_ff.work ? mid : window_ff;

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   // sorting chain
   always_comb begin
      cell_d[0].valid = s1_ff.produce;
      cell_d[0].last  = s1_ff.last;
      cell_d[0].vals  = {right, left, down, up, mid};
      for (int k = 1; k < SORT_CELLS; k++) begin
         cell_d[k] = cell_q[k-1];
      end
   end

   for (genvar k = 0; k < SORT_CELLS; k++) begin : g_cell
      cmdf_sort_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .phase    ((k % 2 == 0) ? PHASE_EVEN : PHASE_ODD),
         .cell_in  (cell_d[k]),
         .cell_out (cell_q[k])
      );
   end

   // result queue
   assign fifo_in.filtered = cell_q[SORT_CELLS-1].vals[MEDIAN_IDX];
   assign fifo_in.last     = cell_q[SORT_CELLS-1].last;

   cmdf_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cell_q[SORT_CELLS-1].valid),
      .push_data  (fifo_in),
      .pop        (rsp_valid && rsp_ready),
      .head_valid (rsp_valid),
      .head_data  (fifo_head),
      .count      (fifo_count)
   );

   assign rsp_filtered   = fifo_head.filtered;
   assign rsp_frame_last = fifo_head.last;

   // accept only while every result in flight has a queue slot
   always_comb begin
      occupancy = OCC_BITS'(fifo_count) + OCC_BITS'(s1_ff.produce);
      for (int k = 0; k < SORT_CELLS; k++) begin
         occupancy = occupancy + OCC_BITS'(cell_q[k].valid);
      end
   end

   assign req_ready = (occupancy < OCC_BITS'(OUT_DEPTH));

endmodule

@@ src/cmdf_checker.sv @@
// Port-level checker for the cross median denoise filter, bound to the top level.
// Depends on cmdf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cmdf_checker import cmdf_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [PIXEL_BITS-1:0]   rsp_filtered,
   input logic                    rsp_frame_last
);

   // a stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // a stalled result keeps its payload
   `ASSERT_CLK(a_data_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_filtered))
   `ASSERT_CLK(a_last_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_frame_last))

   // reset empties the output queue
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // with nothing in flight after reset the block takes input at once
   `ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_ready)

endmodule

bind cross_median_denoise_filter_top cmdf_checker u_checker (.*);

@@ tb/tb_cross_median_denoise_filter_top.sv @@
// Testbench for the cross median denoise filter: streams frames, drains them with
// flush transactions and checks each filtered pixel against a scoreboard predictor.
// Depends on cmdf_pkg and cross_median_denoise_filter_top.
`timescale 1ns / 100ps

module tb_cross_median_denoise_filter_top import cmdf_pkg::*;;

   localparam int CLOCK_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 16;
   localparam int RANDOM_ITEMS = 540;

   // Predictor and result checker for the five-point cross median
   class median_scoreboard;
      pix_type             above_line [MAX_WIDTH];
      pix_type             middle_line [MAX_WIDTH];
      pix_type             left_center;
      int unsigned         column;
      int unsigned         row;
      int unsigned         pending;
      logic [CFG_BITS-1:0] width_reg;
      logic [CFG_BITS-1:0] height_reg;
      out_item_type        expected_q [$];
      int unsigned         errors;

      function new();
         foreach (above_line[i]) begin
            above_line[i]  = '0;
            middle_line[i] = '0;
         end
         left_center = '0;
         column      = 0;
         row         = 0;
         pending     = 0;
         width_reg   = WIDTH_RESET;
         height_reg  = HEIGHT_RESET;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] index, logic [CFG_BITS-1:0] value);
         if (index == REG_FRAME_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
      endfunction

      // Zero acts as one, anything above the maximum acts as the maximum
      static function int unsigned effective_size(logic [CFG_BITS-1:0] value,
                                                  int unsigned limit);
         if (value == 0) return 1;
         if (value > limit) return limit;
         return 32'(value);
      endfunction

      static function pix_type cross_median(pix_type a, pix_type b, pix_type c,
                                            pix_type d, pix_type e);
         pix_type sorted [5];
         pix_type swap;
         sorted = '{a, b, c, d, e};
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4 - i; j++) begin
               if (sorted[j] > sorted[j+1]) begin
                  swap        = sorted[j];
                  sorted[j]   = sorted[j+1];
                  sorted[j+1] = swap;
               end
            end
         end
         return sorted[2];
      endfunction

      // Accepted input transaction: advance the state, queue any result it causes
      function void note_input(logic action, pix_type px);
         int unsigned  w;
         int unsigned  h;
         int unsigned  c;
         pix_type      mid;
         pix_type      up;
         pix_type      left;
         pix_type      right;
         out_item_type item;
         w     = effective_size(width_reg, MAX_WIDTH);
         h     = effective_size(height_reg, MAX_HEIGHT);
         c     = (column < MAX_WIDTH) ? column : MAX_WIDTH - 1;
         mid   = middle_line[c];
         right = (c + 1 >= w) ? mid : middle_line[c+1];

         // Flush: emit one output of the last line
         if (action == ACT_FLUSH) begin
            if (pending == 0) return;
            up   = (h == 1) ? mid : above_line[c];
            left = (c == 0) ? mid : middle_line[c-1];
            pending--;
            item.filtered = cross_median(mid, up, mid, left, right);
            item.last     = (pending == 0);
            expected_q.push_back(item);
            column = (pending == 0) ? 0 : c + 1;
            return;
         end

         // Push: ignored while the previous frame still drains
         if (pending != 0) return;
         if (row >= 1) begin
            up   = (row == 1) ? mid : above_line[c];
            left = (c == 0) ? mid : left_center;
            item.filtered = cross_median(mid, up, px, left, right);
            item.last     = 1'b0;
            expected_q.push_back(item);
         end
         left_center    = mid;
         above_line[c]  = mid;
         middle_line[c] = px;

         // Advance position; frame end arms the drain
         if (c + 1 >= w) begin
            column = 0;
            if (row + 1 >= h) begin
               row     = 0;
               pending = w;
            end else begin
               row++;
            end
         end else begin
            column = c + 1;
         end
      endfunction

      function void flag(string what, int want_v, int got_v);
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
      endfunction

      // Accepted result transaction: compare with the oldest expectation
      function void check_result(pix_type filtered, logic last);
         out_item_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual filtered %0d last %0d",
                     $time, filtered, last);
            return;
         end
         want = expected_q.pop_front();
         if (filtered !== want.filtered) flag("filtered", want.filtered, filtered);
         if (last !== want.last) flag("frame_last", want.last, last);
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_action;
   logic [PIXEL_BITS-1:0]   req_pixel;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [PIXEL_BITS-1:0]   rsp_filtered;
   logic                    rsp_frame_last;
   logic                    csr_write_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   median_scoreboard sb;
   bit               idle_off;
   int unsigned      random_items;

   cross_median_denoise_filter_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .rsp_frame_last (rsp_frame_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      repeat (CLOCK_LIMIT) @(posedge clock);
      $display("%0t: timeout, %0d results outstanding", $time, sb.expected_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: random backpressure, none during the quiet stretch
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = idle_off ? 1'b1 : ($urandom_range(99) >= 17);
      end
   end

   // Result monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_filtered, rsp_frame_last);
      end
   end

   // One input transaction, with random idle cycles ahead of it unless idle_off is set
   task automatic send_item(logic action, pix_type px);
      @(negedge clock);
      if (!idle_off) begin
         while ($urandom_range(99) < 17) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid  = 1'b1;
      req_action = action;
      req_pixel  = px;
      do @(posedge clock); while (!req_ready);
      sb.note_input(action, px);
   endtask

   // Stop sending and wait until every expected result has come
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] index, logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      sb.write_reg(index, value);
   endtask

   // Pixel patterns: full range, black/white, near-flat with ties, ramp
   function automatic pix_type next_pixel(int unsigned mode, pix_type base, int unsigned n);
      case (mode)
         0:       return pix_type'($urandom_range(255));
         1:       return $urandom_range(1) ? 8'hFF : 8'h00;
         2:       return pix_type'(base + $urandom_range(3));
         default: return pix_type'(base + n * 7 + $urandom_range(1));
      endcase
   endfunction

   // Whole frame: size, pixels, drain; noise adds transactions the block ignores
   task automatic run_frame(logic [CFG_BITS-1:0] w_val, logic [CFG_BITS-1:0] h_val,
                            int unsigned mode, int unsigned noise_pct);
      int unsigned w;
      int unsigned h;
      pix_type     base;
      w    = median_scoreboard::effective_size(w_val, MAX_WIDTH);
      h    = median_scoreboard::effective_size(h_val, MAX_HEIGHT);
      base = pix_type'($urandom);
      write_csr(REG_FRAME_WIDTH, w_val);
      write_csr(REG_FRAME_HEIGHT, h_val);
      for (int unsigned n = 0; n < w * h; n++) begin
         if ($urandom_range(99) < noise_pct) send_item(ACT_FLUSH, pix_type'($urandom));
         send_item(ACT_PUSH, next_pixel(mode, base, n));
         if ($urandom_range(999) < 3) settle();
      end
      for (int unsigned n = 0; n < w; n++) begin
         if ($urandom_range(99) < noise_pct) send_item(ACT_PUSH, pix_type'($urandom));
         send_item(ACT_FLUSH, pix_type'($urandom));
      end
      if (noise_pct != 0) send_item(ACT_FLUSH, pix_type'($urandom));
      settle();
   endtask

   // Stimulus
   initial begin
      pix_type two_rows [6];
      pix_type one_row [4];
      logic [CFG_BITS-1:0] w_val;
      logic [CFG_BITS-1:0] h_val;
      int unsigned         frame_no;

      sb           = new();
      idle_off     = 1'b0;
      random_items = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = ACT_PUSH;
      req_pixel    = '0;
      csr_write_en = 1'b0;
      csr_index    = REG_FRAME_WIDTH;
      csr_wdata    = '0;
      two_rows     = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
      one_row      = '{8'hFF, 8'h00, 8'h80, 8'h01};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // 3x2 frame of extremes; flush with nothing pending, pause mid-frame,
      // push while draining, extra flush after the frame
      write_csr(REG_FRAME_WIDTH, 11'd3);
      write_csr(REG_FRAME_HEIGHT, 11'd2);
      send_item(ACT_FLUSH, 8'hFF);
      foreach (two_rows[i]) begin
         send_item(ACT_PUSH, two_rows[i]);
         if (i == 3) settle();
      end
      send_item(ACT_PUSH, 8'hFF);
      repeat (3) send_item(ACT_FLUSH, 8'h00);
      send_item(ACT_FLUSH, 8'h00);
      settle();

      // Single-line frame: up and down both come from the centre
      write_csr(REG_FRAME_WIDTH, 11'd4);
      write_csr(REG_FRAME_HEIGHT, 11'd1);
      foreach (one_row[i]) send_item(ACT_PUSH, one_row[i]);
      repeat (4) send_item(ACT_FLUSH, 8'hFF);
      settle();

      // Single-pixel frame
      write_csr(REG_FRAME_WIDTH, 11'd1);
      send_item(ACT_PUSH, 8'hFF);
      send_item(ACT_FLUSH, 8'h00);
      settle();

      // Zero register values act as one
      run_frame(11'd0, 11'd5, 0, 1);
      run_frame(11'd7, 11'd0, 2, 0);

      // Random small frames; a few of them without any idling
      frame_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         w_val    = CFG_BITS'(($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                       : $urandom_range(12, 1));
         h_val    = CFG_BITS'($urandom_range(6, 1));
         idle_off = (frame_no >= 4 && frame_no < 8);
         run_frame(w_val, h_val, $urandom_range(3), ($urandom_range(3) == 0) ? 10 : 0);
         random_items += w_val * h_val + w_val;
         frame_no++;
      end
      idle_off = 1'b0;

      settle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/cmdf_pkg.sv
src/cmdf_ram.sv
src/cmdf_sort_cell.sv
src/cmdf_out_fifo.sv
src/cross_median_denoise_filter_top.sv
src/cmdf_checker.sv
tb/tb_cross_median_denoise_filter_top.sv
